@@ sv/glzw_pkg.sv @@
// Shared types, codes and constants for the GIF LZW pixel decoder.
package glzw_pkg;

    localparam int DICT_ENTRIES_DEF  = 4096;
    localparam int STACK_DEPTH_DEF   = 4096;
    localparam int MAX_CODE_BITS_DEF = 12;

    localparam int CODE_W  = 12;
    localparam int COUNT_W = 13;
    localparam int DICT_W  = 32;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_PUSH   = 2'd1;
    localparam logic [1:0] OP_PULL   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [3:0]
    {
        K_START = 4'b0001,
        K_PUSH  = 4'b0010,
        K_PULL  = 4'b0100,
        K_NOP   = 4'b1000
    } kind_t;

    typedef struct packed
    {
        kind_t      kind;
        logic [7:0] data;
    } item_t;

    typedef struct packed
    {
        logic               busy;
        logic [COUNT_W-1:0] stack_count;
        logic               stop_seen;
    } back_status_t;

endpackage

@@ sv/gif_lzw_pixel_decoder_top.sv @@
// Top level of the GIF LZW pixel decoder: front queue, decode back end, checks.
// Every beat gives exactly one result beat. Start, push and unused opcodes finish in the cycle
// they leave the queue, so their result appears in the next cycle. A pull that pops a waiting
// pixel goes through the queue pop, the stack read and the registered read data. A pull that
// finds the stack empty first decodes codes: each code is extracted and then classified; for a
// code from the table, the chain walk pushes the root character and, through the registered
// dictionary read, each further character of the expanded string; then the new table entry is
// written unless the table is full, after a patch of the first character in the KwKwK case.
// A two-entry queue in front lets input beats arrive while the back end is busy. Neither RAM
// needs clearing after reset.
module gif_lzw_pixel_decoder_top
    import glzw_pkg::*;
#(
    parameter int DICT_ENTRIES  = DICT_ENTRIES_DEF,
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       accepted,
    output logic       pixel_valid,
    output logic [7:0] pixel_index,
    output logic       image_done,
    output logic       decode_error
);

    logic         q_valid;
    item_t        q_item;
    logic         q_pop;
    back_status_t status;

    glzw_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .data_byte (data_byte),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    glzw_back #(
        .DICT_ENTRIES  (DICT_ENTRIES),
        .STACK_DEPTH   (STACK_DEPTH),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .pixel_valid  (pixel_valid),
        .pixel_index  (pixel_index),
        .image_done   (image_done),
        .decode_error (decode_error),
        .status       (status)
    );

    // The stack never holds more characters than it has slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.stack_count <= COUNT_W'(STACK_DEPTH))
        else $error("string stack count beyond depth");

    // A beat carrying a pixel never also reports a taken byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_valid |-> !accepted)
        else $error("pixel beat flagged as accepted");

    // The back end only takes a queued item while idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid && !status.busy)
        else $error("queue popped while back end busy");

    // Image done is only reported once the stop code has been seen.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && image_done |-> status.stop_seen)
        else $error("image done without stop code");

endmodule

@@ sv/glzw_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module glzw_ram
    import glzw_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/glzw_front.sv @@
// Front end: accepts input beats, classifies the opcode and queues items.
module glzw_front
    import glzw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [7:0] data_byte,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_pop
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push;
    logic        pop;
    item_t       incoming;

    always_comb
    begin
        unique case (opcode)
            OP_START: incoming.kind = K_START;
            OP_PUSH:  incoming.kind = K_PUSH;
            OP_PULL:  incoming.kind = K_PULL;
            default:  incoming.kind = K_NOP;
        endcase
        incoming.data = data_byte;
    end

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

@@ sv/glzw_back.sv @@
// Back end: byte packing, LZW code decoding, chain walk and pixel pops.
module glzw_back
    import glzw_pkg::*;
#(
    parameter int DICT_ENTRIES  = DICT_ENTRIES_DEF,
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  item_t        q_item,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         accepted,
    output logic         pixel_valid,
    output logic [7:0]   pixel_index,
    output logic         image_done,
    output logic         decode_error,
    output back_status_t status
);

    localparam int DAW = $clog2(DICT_ENTRIES);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int TABLE_LIMIT = (DICT_ENTRIES < (1 << MAX_CODE_BITS)) ?
                                 DICT_ENTRIES : (1 << MAX_CODE_BITS);
    localparam logic [COUNT_W-1:0] LIMIT_C = COUNT_W'(TABLE_LIMIT);
    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(STACK_DEPTH);
    localparam logic [3:0]         MAXW_C  = 4'(MAX_CODE_BITS);

    typedef enum logic [8:0]
    {
        S_IDLE   = 9'b000000001,
        S_PULL   = 9'b000000010,
        S_POPRD  = 9'b000000100,
        S_DECODE = 9'b000001000,
        S_WALK   = 9'b000010000,
        S_WALKRD = 9'b000100000,
        S_FIX0   = 9'b001000000,
        S_FINISH = 9'b010000000,
        S_SPARE  = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [31:0]        buf_reg, buf_next;
    logic [5:0]         held_reg, held_next;
    logic [7:0]         sub_reg, sub_next;
    logic [3:0]         cw_reg, cw_next;
    logic [3:0]         root_reg, root_next;
    logic [COUNT_W-1:0] nidx_reg, nidx_next;
    logic [CODE_W-1:0]  prev_reg, prev_next;
    logic [CODE_W-1:0]  plen_reg, plen_next;
    logic               aclr_reg, aclr_next;
    logic               full_reg, full_next;
    logic               stop_reg, stop_next;
    logic               err_reg, err_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [CODE_W-1:0]  walk_reg, walk_next;
    logic               kwk_reg, kwk_next;
    logic [7:0]         first_reg, first_next;

    logic               ov_reg;
    logic               acc_reg, pv_reg, done_reg, derr_reg;
    logic [7:0]         pix_reg;
    logic               emit;
    logic               emit_acc, emit_pv;
    logic [7:0]         emit_pix;

    logic               s_we;
    logic [SAW-1:0]     s_waddr, s_raddr;
    logic [7:0]         s_wdata, s_rdata;
    logic               d_we;
    logic [DAW-1:0]     d_waddr, d_raddr;
    logic [DICT_W-1:0]  d_wdata, d_rdata;

    logic               out_free;
    logic [COUNT_W-1:0] clear_code;
    logic [CODE_W-1:0]  clear12;
    logic [31:0]        mask;
    logic [3:0]         root_clamp;
    logic [COUNT_W-1:0] nidx_inc;
    logic [COUNT_W-1:0] count_m1;

    glzw_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack
    (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    glzw_ram #(.WIDTH(DICT_W), .DEPTH(DICT_ENTRIES)) u_dict
    (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    assign out_free   = !ov_reg || !out_stall;
    assign clear_code = COUNT_W'(1) << root_reg;
    assign clear12    = clear_code[CODE_W-1:0];
    assign mask       = (32'd1 << cw_reg) - 32'd1;
    assign nidx_inc   = nidx_reg + COUNT_W'(1);
    assign count_m1   = count_reg - COUNT_W'(1);
    assign root_clamp = (q_item.data < 8'd2) ? 4'd2 :
                        ((q_item.data > 8'd8) ? 4'd8 : q_item.data[3:0]);
    assign s_raddr    = count_m1[SAW-1:0];
    assign d_raddr    = walk_reg[DAW-1:0];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        buf_next   = buf_reg;
        held_next  = held_reg;
        sub_next   = sub_reg;
        cw_next    = cw_reg;
        root_next  = root_reg;
        nidx_next  = nidx_reg;
        prev_next  = prev_reg;
        plen_next  = plen_reg;
        aclr_next  = aclr_reg;
        full_next  = full_reg;
        stop_next  = stop_reg;
        err_next   = err_reg;
        code_next  = code_reg;
        walk_next  = walk_reg;
        kwk_next   = kwk_reg;
        first_next = first_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        emit_acc   = 1'b0;
        emit_pv    = 1'b0;
        emit_pix   = 8'd0;
        s_we       = 1'b0;
        s_waddr    = count_reg[SAW-1:0];
        s_wdata    = 8'd0;
        d_we       = 1'b0;
        d_waddr    = nidx_reg[DAW-1:0];
        d_wdata    = {plen_reg + CODE_W'(1), prev_reg, first_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    unique case (q_item.kind)
                        K_START:
                        begin
                            root_next  = root_clamp;
                            count_next = '0;
                            buf_next   = '0;
                            held_next  = '0;
                            sub_next   = '0;
                            prev_next  = '0;
                            plen_next  = '0;
                            stop_next  = 1'b0;
                            err_next   = 1'b0;
                            cw_next    = root_clamp + 4'd1;
                            nidx_next  = (COUNT_W'(1) << root_clamp) + COUNT_W'(2);
                            aclr_next  = 1'b1;
                            full_next  = 1'b0;
                            emit       = 1'b1;
                            emit_acc   = 1'b1;
                        end
                        K_PUSH:
                        begin
                            emit = 1'b1;
                            if (sub_reg == 8'd0)
                            begin
                                sub_next = q_item.data;
                                emit_acc = 1'b1;
                            end
                            else if (stop_reg || err_reg)
                            begin
                                sub_next = sub_reg - 8'd1;
                                emit_acc = 1'b1;
                            end
                            else if (held_reg <= 6'd24)
                            begin
                                buf_next  = buf_reg | ({24'd0, q_item.data} << held_reg);
                                held_next = held_reg + 6'd8;
                                sub_next  = sub_reg - 8'd1;
                                emit_acc  = 1'b1;
                            end
                        end
                        K_PULL:
                        begin
                            state_next = S_PULL;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_PULL:
            begin
                if (count_reg == '0 && !stop_reg && !err_reg &&
                    held_reg >= {2'b00, cw_reg})
                begin
                    code_next  = CODE_W'(buf_reg & mask);
                    buf_next   = buf_reg >> cw_reg;
                    held_next  = held_reg - {2'b00, cw_reg};
                    state_next = S_DECODE;
                end
                else if (count_reg != '0)
                begin
                    count_next = count_m1;
                    state_next = S_POPRD;
                end
                else
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_POPRD:
            begin
                emit       = 1'b1;
                emit_pv    = 1'b1;
                emit_pix   = s_rdata;
                state_next = S_IDLE;
            end
            S_DECODE:
            begin
                state_next = S_PULL;
                if (code_reg == clear12)
                begin
                    cw_next   = root_reg + 4'd1;
                    nidx_next = clear_code + COUNT_W'(2);
                    aclr_next = 1'b1;
                    full_next = 1'b0;
                end
                else if (code_reg == clear12 + CODE_W'(1))
                begin
                    stop_next = 1'b1;
                end
                else if (aclr_reg)
                begin
                    if (code_reg >= clear12)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        if (count_reg < DEPTH_C)
                        begin
                            s_we       = 1'b1;
                            s_wdata    = code_reg[7:0];
                            count_next = count_reg + COUNT_W'(1);
                        end
                        prev_next = code_reg;
                        plen_next = CODE_W'(1);
                        aclr_next = 1'b0;
                    end
                end
                else if ({1'b0, code_reg} > nidx_reg ||
                         ({1'b0, code_reg} == nidx_reg && full_reg))
                begin
                    err_next = 1'b1;
                end
                else if ({1'b0, code_reg} < nidx_reg)
                begin
                    walk_next  = code_reg;
                    kwk_next   = 1'b0;
                    state_next = S_WALK;
                end
                else
                begin
                    // The code names the entry about to be made: previous string plus
                    // its own first character, whose slot is patched after the walk.
                    if (count_reg < DEPTH_C)
                    begin
                        s_we       = 1'b1;
                        s_wdata    = 8'd0;
                        count_next = count_reg + COUNT_W'(1);
                    end
                    walk_next  = prev_reg;
                    kwk_next   = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (walk_reg < clear12)
                begin
                    if (count_reg < DEPTH_C)
                    begin
                        s_we       = 1'b1;
                        s_wdata    = walk_reg[7:0];
                        count_next = count_reg + COUNT_W'(1);
                        first_next = walk_reg[7:0];
                    end
                    state_next = kwk_reg ? S_FIX0 : S_FINISH;
                end
                else
                begin
                    state_next = S_WALKRD;
                end
            end
            S_WALKRD:
            begin
                if (count_reg < DEPTH_C)
                begin
                    s_we       = 1'b1;
                    s_wdata    = d_rdata[7:0];
                    count_next = count_reg + COUNT_W'(1);
                    first_next = d_rdata[7:0];
                end
                walk_next  = d_rdata[19:8];
                state_next = S_WALK;
            end
            S_FIX0:
            begin
                s_we       = 1'b1;
                s_waddr    = '0;
                s_wdata    = first_reg;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!full_reg)
                begin
                    d_we      = 1'b1;
                    nidx_next = nidx_inc;
                    if (nidx_inc >= LIMIT_C)
                    begin
                        full_next = 1'b1;
                    end
                    else if (nidx_inc == (COUNT_W'(1) << cw_reg) && cw_reg < MAXW_C)
                    begin
                        cw_next = cw_reg + 4'd1;
                    end
                end
                prev_next  = code_reg;
                plen_next  = count_reg[CODE_W-1:0];
                state_next = S_PULL;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            buf_reg   <= '0;
            held_reg  <= '0;
            sub_reg   <= '0;
            cw_reg    <= 4'd3;
            root_reg  <= 4'd2;
            nidx_reg  <= COUNT_W'(6);
            prev_reg  <= '0;
            plen_reg  <= '0;
            aclr_reg  <= 1'b1;
            full_reg  <= 1'b0;
            stop_reg  <= 1'b0;
            err_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            buf_reg   <= buf_next;
            held_reg  <= held_next;
            sub_reg   <= sub_next;
            cw_reg    <= cw_next;
            root_reg  <= root_next;
            nidx_reg  <= nidx_next;
            prev_reg  <= prev_next;
            plen_reg  <= plen_next;
            aclr_reg  <= aclr_next;
            full_reg  <= full_next;
            stop_reg  <= stop_next;
            err_reg   <= err_next;
            if (emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        walk_reg  <= walk_next;
        kwk_reg   <= kwk_next;
        first_reg <= first_next;
        if (emit)
        begin
            acc_reg  <= emit_acc;
            pv_reg   <= emit_pv;
            pix_reg  <= emit_pix;
            done_reg <= stop_next && (count_next == '0);
            derr_reg <= err_next;
        end
    end

    assign out_valid    = ov_reg;
    assign accepted     = acc_reg;
    assign pixel_valid  = pv_reg;
    assign pixel_index  = pix_reg;
    assign image_done   = done_reg;
    assign decode_error = derr_reg;

    assign status.busy        = (state_reg != S_IDLE);
    assign status.stack_count = count_reg;
    assign status.stop_seen   = stop_reg;

endmodule
